// ===== rtl/core/hermite_curve_point_table_defines.svh =====
// ----------------------------------------------------------------------------
// hermite curve point table assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HERMITE_CURVE_POINT_TABLE_DEFINES_SVH
`define HERMITE_CURVE_POINT_TABLE_DEFINES_SVH

// same-cycle implication
`define HCPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcpt check failed");

// next-cycle implication
`define HCPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcpt check failed");

`endif

// ===== rtl/core/hcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hcpt_pkg
// shared types and constants of the hermite curve point table
// ----------------------------------------------------------------------------
package hcpt_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ROT,
    T_LAUNCH,
    T_EVAL
  } top_state_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_DIV,
    E_SQ,
    E_CUBE,
    E_BASIS,
    E_TERM,
    E_TAN,
    E_LO,
    E_HI,
    E_ACC
  } ev_state_t;

  typedef struct packed {
    logic        [31:0] tm;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } point_t;

  typedef struct packed {
    logic        ins;
    logic        rot;
    logic [31:0] q;
    point_t      pt;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/hcpt_cell.sv =====
// ----------------------------------------------------------------------------
// hcpt_cell
// one table slot: holds a point, shifts up on insert, rotates down on search
// ----------------------------------------------------------------------------
module hcpt_cell import hcpt_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid,
  input  logic       prev_le,
  input  logic       prev_valid,
  input  point_t     prev_pt,
  input  point_t     next_pt,
  output point_t     pt,
  output logic       le
);

  point_t pt_r;
  point_t pt_nxt;

  assign pt = pt_r;
  assign le = valid && (pt_r.tm <= ctrl.q);

  always_comb begin
    pt_nxt = pt_r;
    if (ctrl.rot) begin
      pt_nxt = next_pt;
    end else if (ctrl.ins) begin
      if (prev_valid && !prev_le) begin
        pt_nxt = prev_pt;
      end else if (prev_le && !le) begin
        pt_nxt = ctrl.pt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

endmodule

// ===== rtl/core/hcpt_eval.sv =====
// ----------------------------------------------------------------------------
// hcpt_eval
// segment fraction by restoring division, then hermite blend per axis
// on one shared multiplier
// ----------------------------------------------------------------------------
module hcpt_eval import hcpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic        [31:0] q,
  input  point_t             p0,
  input  point_t             p1,
  output logic               done,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z
);

  localparam logic signed [35:0] ONE_Q32 = 36'sh1_0000_0000;
  localparam logic signed [52:0] SAT_HI  = 53'sd2147483647;
  localparam logic signed [52:0] SAT_LO  = -53'sd2147483648;

  ev_state_t          state_r, state_nxt;
  logic        [31:0] rem_r, rem_nxt;
  logic        [31:0] h_r, h_nxt;
  logic        [31:0] quo_r, quo_nxt;
  logic        [4:0]  it_r, it_nxt;
  logic        [65:0] prod_r, prod_nxt;
  logic        [31:0] u2_r, u2_nxt;
  logic        [32:0] fmag_r [3];
  logic        [32:0] fmag_nxt [3];
  logic        [2:0]  fneg_r, fneg_nxt;
  logic        [47:0] vmag_r, vmag_nxt;
  logic               vneg_r, vneg_nxt;
  logic        [32:0] lo_r, lo_nxt;
  logic signed [52:0] acc_r, acc_nxt;
  axis_t              axis_r, axis_nxt;
  logic        [1:0]  term_r, term_nxt;
  logic signed [31:0] rx_r, rx_nxt, ry_r, ry_nxt, rz_r, rz_nxt;
  logic               done_r, done_nxt;

  logic        [32:0] sh;
  logic               ge;
  logic signed [35:0] su, su2, su3, b01, b10, b11;
  logic        [33:0] f01, f10, f11;
  logic signed [31:0] p0a, p1a, m0a, m1a, ma;
  logic signed [32:0] diff;
  logic        [32:0] diff_mag;
  logic        [31:0] m_mag;
  logic        [49:0] r_mag;
  logic signed [52:0] r_s, acc_sum, acc_p0;
  logic signed [31:0] acc_sat;

  function automatic logic [33:0] frac_sm(input logic signed [35:0] v);
    logic signed [35:0] c;
    logic        [35:0] m;
    if (v > ONE_Q32) begin
      c = ONE_Q32;
    end else if (v < -ONE_Q32) begin
      c = -ONE_Q32;
    end else begin
      c = v;
    end
    m = c[35] ? $unsigned(-c) : $unsigned(c);
    return {c[35], m[32:0]};
  endfunction

  function automatic logic signed [31:0] pos_of(input point_t p, input axis_t a);
    case (a)
      AX_X:    return p.px;
      AX_Y:    return p.py;
      AX_Z:    return p.pz;
      default: return p.px;
    endcase
  endfunction

  function automatic logic signed [31:0] tan_of(input point_t p, input axis_t a);
    case (a)
      AX_X:    return p.tx;
      AX_Y:    return p.ty;
      AX_Z:    return p.tz;
      default: return p.tx;
    endcase
  endfunction

  assign done  = done_r;
  assign res_x = rx_r;
  assign res_y = ry_r;
  assign res_z = rz_r;

  always_comb begin
    sh       = {rem_r, 1'b0};
    ge       = sh >= {1'b0, h_r};
    su       = {4'b0, quo_r};
    su2      = {4'b0, u2_r};
    su3      = {4'b0, prod_r[63:32]};
    b01      = (su2 <<< 1) + su2 - (su3 <<< 1);
    b10      = su3 - (su2 <<< 1) + su;
    b11      = su3 - su2;
    f01      = frac_sm(b01);
    f10      = frac_sm(b10);
    f11      = frac_sm(b11);
    p0a      = pos_of(p0, axis_r);
    p1a      = pos_of(p1, axis_r);
    m0a      = tan_of(p0, axis_r);
    m1a      = tan_of(p1, axis_r);
    ma       = (term_r == 2'd1) ? m0a : m1a;
    diff     = {p1a[31], p1a} - {p0a[31], p0a};
    diff_mag = diff[32] ? $unsigned(-diff) : $unsigned(diff);
    m_mag    = ma[31] ? $unsigned(-ma) : $unsigned(ma);
    r_mag    = prod_r[49:0] + {17'b0, lo_r};
    r_s      = $signed({3'b0, r_mag});
    acc_sum  = acc_r + ((vneg_r ^ fneg_r[term_r]) ? -r_s : r_s);
    acc_p0   = {{21{p0a[31]}}, p0a};
    if (acc_sum > SAT_HI) begin
      acc_sat = 32'sh7fff_ffff;
    end else if (acc_sum < SAT_LO) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    h_nxt     = h_r;
    quo_nxt   = quo_r;
    it_nxt    = it_r;
    prod_nxt  = prod_r;
    u2_nxt    = u2_r;
    fmag_nxt  = fmag_r;
    fneg_nxt  = fneg_r;
    vmag_nxt  = vmag_r;
    vneg_nxt  = vneg_r;
    lo_nxt    = lo_r;
    acc_nxt   = acc_r;
    axis_nxt  = axis_r;
    term_nxt  = term_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    rz_nxt    = rz_r;
    done_nxt  = 1'b0;
    case (state_r)
      E_IDLE: begin
        if (start) begin
          rem_nxt   = q - p0.tm;
          h_nxt     = p1.tm - p0.tm;
          quo_nxt   = '0;
          it_nxt    = '0;
          state_nxt = E_DIV;
        end
      end
      E_DIV: begin
        rem_nxt = ge ? 32'(sh - {1'b0, h_r}) : sh[31:0];
        quo_nxt = {quo_r[30:0], ge};
        it_nxt  = it_r + 5'd1;
        if (it_r == 5'd31) begin
          state_nxt = E_SQ;
        end
      end
      E_SQ: begin
        prod_nxt  = 66'(quo_r * quo_r);
        state_nxt = E_CUBE;
      end
      E_CUBE: begin
        u2_nxt    = prod_r[63:32];
        prod_nxt  = 66'(prod_r[63:32] * quo_r);
        state_nxt = E_BASIS;
      end
      E_BASIS: begin
        fneg_nxt    = {f11[33], f10[33], f01[33]};
        fmag_nxt[0] = f01[32:0];
        fmag_nxt[1] = f10[32:0];
        fmag_nxt[2] = f11[32:0];
        axis_nxt    = AX_X;
        term_nxt    = 2'd0;
        state_nxt   = E_TERM;
      end
      E_TERM: begin
        if (term_r == 2'd0) begin
          acc_nxt   = acc_p0;
          vmag_nxt  = {15'b0, diff_mag};
          vneg_nxt  = diff[32];
          state_nxt = E_LO;
        end else begin
          prod_nxt  = 66'(m_mag * h_r);
          vneg_nxt  = ma[31];
          state_nxt = E_TAN;
        end
      end
      E_TAN: begin
        vmag_nxt  = prod_r[63:16];
        state_nxt = E_LO;
      end
      E_LO: begin
        prod_nxt  = 66'(vmag_r[31:0] * fmag_r[term_r]);
        state_nxt = E_HI;
      end
      E_HI: begin
        lo_nxt    = prod_r[64:32];
        prod_nxt  = 66'(vmag_r[47:32] * fmag_r[term_r]);
        state_nxt = E_ACC;
      end
      E_ACC: begin
        acc_nxt = acc_sum;
        if (term_r == 2'd2) begin
          term_nxt = 2'd0;
          case (axis_r)
            AX_X:    rx_nxt = acc_sat;
            AX_Y:    ry_nxt = acc_sat;
            default: rz_nxt = acc_sat;
          endcase
          if (axis_r == AX_Z) begin
            done_nxt  = 1'b1;
            state_nxt = E_IDLE;
          end else begin
            axis_nxt  = (axis_r == AX_X) ? AX_Y : AX_Z;
            state_nxt = E_TERM;
          end
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = E_TERM;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    h_r    <= h_nxt;
    quo_r  <= quo_nxt;
    it_r   <= it_nxt;
    prod_r <= prod_nxt;
    u2_r   <= u2_nxt;
    fmag_r <= fmag_nxt;
    fneg_r <= fneg_nxt;
    vmag_r <= vmag_nxt;
    vneg_r <= vneg_nxt;
    lo_r   <= lo_nxt;
    acc_r  <= acc_nxt;
    axis_r <= axis_nxt;
    term_r <= term_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    rz_r   <= rz_nxt;
  end

endmodule

// ===== rtl/core/hermite_curve_point_table.sv =====
// ----------------------------------------------------------------------------
// hermite_curve_point_table
// time-sorted chain of point cells with a hermite curve evaluator
//
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   operation, point_time, pos_*_in, tan_*_in
// out_      output     out_valid / out_ready status, pos_*_out, segment_end
//
// clear, insert and unused codes are answered in the cycle after they are taken; insert shifts the chain once
// query: the chain rotates through all MAX_POINTS cells, then the evaluator runs
//   (launch, 32 division steps, square, cube and basis, then 3 axes in turn); the result
//   item is registered once the evaluator is done, or after the rotation if out of range
// a result waits in the output register; new items are taken once it is free
// reset empties the table; table contents are not cleared
// ----------------------------------------------------------------------------
module hermite_curve_point_table import hcpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  in_operation,
  input  logic        [31:0] in_point_time,
  input  logic signed [31:0] in_pos_x_in,
  input  logic signed [31:0] in_pos_y_in,
  input  logic signed [31:0] in_pos_z_in,
  input  logic signed [31:0] in_tan_x_in,
  input  logic signed [31:0] in_tan_y_in,
  input  logic signed [31:0] in_tan_z_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [1:0]  out_status,
  output logic signed [31:0] out_pos_x_out,
  output logic signed [31:0] out_pos_y_out,
  output logic signed [31:0] out_pos_z_out,
  output logic        [4:0]  out_segment_end
);

  top_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   rot_r, rot_nxt;
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   seg_r, seg_nxt;
  logic [31:0]        q_r, q_nxt;
  point_t             p0_r, p0_nxt, p1_r, p1_nxt;
  logic               ov_r, ov_nxt;
  status_t            os_r, os_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [4:0]         oseg_r, oseg_nxt;

  cell_ctrl_t              ctrl;
  point_t                  pts [MAX_POINTS];
  logic [MAX_POINTS-1:0]   le;
  logic [MAX_POINTS-1:0]   valid;
  logic                    slot_free, acc_in, hit, ev_done;
  logic signed [31:0]      ev_x, ev_y, ev_z;
  op_t                     op;

  assign op        = op_t'(in_operation);
  assign slot_free = !ov_r || out_ready;
  assign in_ready  = (state_r == T_IDLE) && slot_free;
  assign acc_in    = in_valid && in_ready;

  assign ctrl.ins = acc_in && (op == OP_INSERT) && (count_r < CNT_W'(MAX_POINTS));
  assign ctrl.rot = (state_r == T_ROT);
  assign ctrl.q   = in_point_time;
  assign ctrl.pt  = '{tm: in_point_time, px: in_pos_x_in, py: in_pos_y_in,
                      pz: in_pos_z_in, tx: in_tan_x_in, ty: in_tan_y_in,
                      tz: in_tan_z_in};

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign valid[i] = CNT_W'(i) < count_r;
    if (i == 0) begin : g_first
      hcpt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (valid[i]),
        .prev_le   (1'b1),
        .prev_valid(1'b0),
        .prev_pt   (pts[MAX_POINTS-1]),
        .next_pt   (pts[(i+1) % MAX_POINTS]),
        .pt        (pts[i]),
        .le        (le[i])
      );
    end else begin : g_rest
      hcpt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (valid[i]),
        .prev_le   (le[i-1]),
        .prev_valid(valid[i-1]),
        .prev_pt   (pts[i-1]),
        .next_pt   (pts[(i+1) % MAX_POINTS]),
        .pt        (pts[i]),
        .le        (le[i])
      );
    end
  end

  hcpt_eval u_eval (
    .clk  (clk),
    .rst_n(rst_n),
    .start(state_r == T_LAUNCH),
    .q    (q_r),
    .p0   (p0_r),
    .p1   (p1_r),
    .done (ev_done),
    .res_x(ev_x),
    .res_y(ev_y),
    .res_z(ev_z)
  );

  assign hit = (pts[0].tm <= q_r) && (q_r < pts[1].tm)
            && ((CNT_W'(rot_r) + CNT_W'(1)) < count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rot_nxt   = rot_r;
    found_nxt = found_r;
    seg_nxt   = seg_r;
    q_nxt     = q_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    ov_nxt    = ov_r && !out_ready;
    os_nxt    = os_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oz_nxt    = oz_r;
    oseg_nxt  = oseg_r;
    case (state_r)
      T_IDLE: begin
        if (acc_in) begin
          ox_nxt   = '0;
          oy_nxt   = '0;
          oz_nxt   = '0;
          oseg_nxt = '0;
          os_nxt   = ST_OK;
          ov_nxt   = 1'b1;
          case (op)
            OP_CLEAR: count_nxt = '0;
            OP_INSERT: begin
              if (count_r < CNT_W'(MAX_POINTS)) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                os_nxt = ST_FULL;
              end
            end
            OP_QUERY: begin
              if (count_r < CNT_W'(2)) begin
                os_nxt = ST_FEW;
              end else begin
                ov_nxt    = 1'b0;
                q_nxt     = in_point_time;
                rot_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = T_ROT;
              end
            end
            default: os_nxt = ST_OK;
          endcase
        end
      end
      T_ROT: begin
        rot_nxt = rot_r + IDX_W'(1);
        if (hit && !found_r) begin
          found_nxt = 1'b1;
          seg_nxt   = CNT_W'(rot_r) + CNT_W'(1);
          p0_nxt    = pts[0];
          p1_nxt    = pts[1];
        end
        if (rot_r == IDX_W'(MAX_POINTS - 1)) begin
          if (found_r || hit) begin
            state_nxt = T_LAUNCH;
          end else begin
            ov_nxt    = 1'b1;
            os_nxt    = ST_RANGE;
            state_nxt = T_IDLE;
          end
        end
      end
      T_LAUNCH: state_nxt = T_EVAL;
      T_EVAL: begin
        if (ev_done) begin
          ov_nxt    = 1'b1;
          os_nxt    = ST_OK;
          ox_nxt    = ev_x;
          oy_nxt    = ev_y;
          oz_nxt    = ev_z;
          oseg_nxt  = 5'(seg_r);
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      found_r <= 1'b0;
      rot_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      found_r <= found_nxt;
      rot_r   <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r  <= seg_nxt;
    q_r    <= q_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    os_r   <= os_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oz_r   <= oz_nxt;
    oseg_r <= oseg_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_pos_x_out   = ox_r;
  assign out_pos_y_out   = oy_r;
  assign out_pos_z_out   = oz_r;
  assign out_segment_end = oseg_r;

endmodule

// ===== rtl/core/hcpt_checker.sv =====
// ----------------------------------------------------------------------------
// hcpt_checker
// port-level checks of the hermite curve point table
// ----------------------------------------------------------------------------
`include "hermite_curve_point_table_defines.svh"

module hcpt_checker import hcpt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic        [1:0]  in_operation,
  input logic        [31:0] in_point_time,
  input logic signed [31:0] in_pos_x_in,
  input logic signed [31:0] in_pos_y_in,
  input logic signed [31:0] in_pos_z_in,
  input logic signed [31:0] in_tan_x_in,
  input logic signed [31:0] in_tan_y_in,
  input logic signed [31:0] in_tan_z_in,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [1:0]  out_status,
  input logic signed [31:0] out_pos_x_out,
  input logic signed [31:0] out_pos_y_out,
  input logic signed [31:0] out_pos_z_out,
  input logic        [4:0]  out_segment_end
);

  // stalled item holds
  `HCPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_pos_x_out))

  // failed item carries no position
  `HCPT_ASSERT_NOW(a_fail_zero, out_valid && (out_status != ST_OK), (out_pos_x_out == 0) && (out_pos_y_out == 0) && (out_pos_z_out == 0) && (out_segment_end == 0))

  // segment end stays inside the table
  `HCPT_ASSERT_NOW(a_seg_range, out_valid, out_segment_end < 5'(MAX_POINTS))

  // clear answers at once with ok
  `HCPT_ASSERT_NEXT(a_clear_ok, in_valid && in_ready && (in_operation == OP_CLEAR), out_valid && (out_status == ST_OK) && (out_segment_end == 0))

endmodule

bind hermite_curve_point_table hcpt_checker u_hcpt_checker (.*);

// ===== verif/hermite_curve_point_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_curve_point_table_checker
// watches both channels, models the sorted point table and the hermite
// evaluation, and compares every result item field by field in order
// ----------------------------------------------------------------------------
module hermite_curve_point_table_checker import hcpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [1:0]  in_operation,
  input  logic        [31:0] in_point_time,
  input  logic signed [31:0] in_pos_x_in,
  input  logic signed [31:0] in_pos_y_in,
  input  logic signed [31:0] in_pos_z_in,
  input  logic signed [31:0] in_tan_x_in,
  input  logic signed [31:0] in_tan_y_in,
  input  logic signed [31:0] in_tan_z_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [1:0]  out_status,
  input  logic signed [31:0] out_pos_x_out,
  input  logic signed [31:0] out_pos_y_out,
  input  logic signed [31:0] out_pos_z_out,
  input  logic        [4:0]  out_segment_end,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 ok_query_count
);

  typedef struct packed {
    status_t            st;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [4:0]  seg;
  } curve_result_t;

  curve_result_t result_fifo[$];
  point_t        pts[MAX_POINTS];
  int            npts;

  localparam longint ONE32 = 64'sd4294967296;

  function automatic longint frac_mul(longint v, longint f);
    logic   neg;
    longint mv, mf, r;
    neg = 1'b0;
    if (f > ONE32) f = ONE32;
    if (f < -ONE32) f = -ONE32;
    if (v < 0) begin mv = -v; neg = ~neg; end else mv = v;
    if (f < 0) begin mf = -f; neg = ~neg; end else mf = f;
    r = (mv >>> 32) * mf + (((mv & 64'hFFFF_FFFF) * mf) >>> 32);
    return neg ? -r : r;
  endfunction

  function automatic longint span_tangent(logic signed [31:0] m, logic [31:0] h);
    longint sm, r;
    sm = longint'(m);
    r = ((sm < 0 ? -sm : sm) * longint'({32'd0, h})) >>> 16;
    return sm < 0 ? -r : r;
  endfunction

  function automatic logic signed [31:0] axis_value(
      logic signed [31:0] p0, logic signed [31:0] p1,
      logic signed [31:0] m0, logic signed [31:0] m1,
      logic [31:0] h, longint b01, longint b10, longint b11);
    longint acc;
    acc = longint'(p0) + frac_mul(longint'(p1) - longint'(p0), b01)
        + frac_mul(span_tangent(m0, h), b10) + frac_mul(span_tangent(m1, h), b11);
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic curve_result_t apply_item(op_t op, point_t p);
    curve_result_t r;
    int k;
    logic [31:0] h, dt;
    logic [63:0] u, u2, u3;
    longint b01, b10, b11;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_CLEAR: npts = 0;
      OP_INSERT: begin
        if (npts >= MAX_POINTS) begin
          r.st = ST_FULL;
        end else begin
          k = 0;
          while (k < npts && pts[k].tm <= p.tm) k++;
          for (int i = npts; i > k; i--) pts[i] = pts[i-1];
          pts[k] = p;
          npts++;
        end
      end
      OP_QUERY: begin
        if (npts < 2) begin
          r.st = ST_FEW;
        end else if (p.tm < pts[0].tm || p.tm >= pts[npts-1].tm) begin
          r.st = ST_RANGE;
        end else begin
          k = 1;
          while (k < npts - 1 && pts[k].tm <= p.tm) k++;
          h  = pts[k].tm - pts[k-1].tm;
          dt = p.tm - pts[k-1].tm;
          u  = {dt, 32'd0} / {32'd0, h};
          u2 = (u * u) >> 32;
          u3 = (u2 * u) >> 32;
          b01 = 3 * longint'(u2) - 2 * longint'(u3);
          b10 = longint'(u3) - 2 * longint'(u2) + longint'(u);
          b11 = longint'(u3) - longint'(u2);
          r.x = axis_value(pts[k-1].px, pts[k].px, pts[k-1].tx, pts[k].tx, h, b01, b10, b11);
          r.y = axis_value(pts[k-1].py, pts[k].py, pts[k-1].ty, pts[k].ty, h, b01, b10, b11);
          r.z = axis_value(pts[k-1].pz, pts[k].pz, pts[k-1].tz, pts[k].tz, h, b01, b10, b11);
          r.seg = k[4:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = result_fifo.size();

  always @(posedge clk) begin
    point_t        p;
    curve_result_t e;
    if (!rst_n) begin
      npts = 0;
      result_fifo.delete();
      fail_count <= 0;
      result_count <= 0;
      ok_query_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        p = '{in_point_time, in_pos_x_in, in_pos_y_in, in_pos_z_in,
              in_tan_x_in, in_tan_y_in, in_tan_z_in};
        result_fifo.insert(result_fifo.size(), apply_item(op_t'(in_operation), p));
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (result_fifo.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = result_fifo.pop_front();
          if (e.st == ST_OK && e.seg != 0) ok_query_count <= ok_query_count + 1;
          if (out_status != e.st || out_pos_x_out != e.x || out_pos_y_out != e.y ||
              out_pos_z_out != e.z || out_segment_end != e.seg) begin
            fail_count <= fail_count + 1;
            if (out_status != e.st)
              $error("status expected %0d actual %0d", e.st, out_status);
            if (out_pos_x_out != e.x)
              $error("pos_x_out expected %0d actual %0d", e.x, out_pos_x_out);
            if (out_pos_y_out != e.y)
              $error("pos_y_out expected %0d actual %0d", e.y, out_pos_y_out);
            if (out_pos_z_out != e.z)
              $error("pos_z_out expected %0d actual %0d", e.z, out_pos_z_out);
            if (out_segment_end != e.seg)
              $error("segment_end expected %0d actual %0d", e.seg, out_segment_end);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_hermite_curve_point_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hermite_curve_point_table
// drives clear, insert, query and unused-code items with random idling on both channels;
// the checker predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module tb_hermite_curve_point_table;
  import hcpt_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic        [1:0]  in_operation;
  logic        [31:0] in_point_time;
  logic signed [31:0] in_pos_x_in, in_pos_y_in, in_pos_z_in;
  logic signed [31:0] in_tan_x_in, in_tan_y_in, in_tan_z_in;
  logic               out_valid;
  logic               out_ready;
  logic        [1:0]  out_status;
  logic signed [31:0] out_pos_x_out, out_pos_y_out, out_pos_z_out;
  logic        [4:0]  out_segment_end;
  int                 fail_count, pending_count, result_count, ok_query_count;
  int                 item_count;

  hermite_curve_point_table u_top (.*);

  hermite_curve_point_table_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("hermite_curve_point_table verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // receiver stalls
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(op_t op, logic [31:0] t, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [31:0] tx, logic [31:0] ty,
                           logic [31:0] tz);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_point_time <= t;
    in_pos_x_in   <= px;
    in_pos_y_in   <= py;
    in_pos_z_in   <= pz;
    in_tan_x_in   <= tx;
    in_tan_y_in   <= ty;
    in_tan_z_in   <= tz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  task automatic send_point(op_t op, logic [31:0] t);
    send_item(op, t, any_word(), any_word(), any_word(),
              any_word(), any_word(), any_word());
  endtask

  initial begin
    logic [31:0] base, span;
    int          n;
    item_count    = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_CLEAR;
    in_point_time = '0;
    in_pos_x_in   = '0;
    in_pos_y_in   = '0;
    in_pos_z_in   = '0;
    in_tan_x_in   = '0;
    in_tan_y_in   = '0;
    in_tan_z_in   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and single point queries, extremes, ties, full table
    send_item(OP_QUERY, 32'd5, '0, '0, '0, '0, '0, '0);
    send_item(OP_NONE, 32'hFFFF_FFFF, '1, '1, '1, '1, '1, '1);
    send_item(OP_INSERT, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_item(OP_QUERY, 32'd0, '0, '0, '0, '0, '0, '0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    send_item(OP_QUERY, 32'd0, '0, '0, '0, '0, '0, '0);
    send_item(OP_QUERY, 32'h8000_0000, '0, '0, '0, '0, '0, '0);
    send_item(OP_QUERY, 32'hFFFF_FFFE, '0, '0, '0, '0, '0, '0);
    send_item(OP_QUERY, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
    send_point(OP_INSERT, 32'h0001_0000);
    send_point(OP_INSERT, 32'h0001_0000);
    send_item(OP_QUERY, 32'h0001_0000, '0, '0, '0, '0, '0, '0);
    send_item(OP_QUERY, 32'h0000_FFFF, '0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 13; i++) send_point(OP_INSERT, $urandom());
    send_item(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_QUERY, 32'd1, '0, '0, '0, '0, '0, '0);

    // random: mostly fill then query, some noise
    while (item_count < 1450) begin
      send_item(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom());
      base = $urandom();
      span = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 32'h0010_0000) : $urandom();
      n = $urandom_range(0, 18);
      for (int i = 0; i < n; i++)
        send_point(OP_INSERT, ($urandom_range(0, 4) == 0) ? $urandom() :
                   base + $urandom_range(0, span));
      repeat ($urandom_range(2, 12)) begin
        case ($urandom_range(0, 9))
          0: send_point(op_t'($urandom_range(1, 3)), $urandom());
          1: send_point(OP_QUERY, $urandom());
          default: send_point(OP_QUERY, base + $urandom_range(0, span));
        endcase
      end
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("items sent %0d, results checked %0d, in-range queries %0d",
             item_count, result_count, ok_query_count);
    if (fail_count == 0) begin
      $display("hermite_curve_point_table verification clean");
    end else begin
      $display("hermite_curve_point_table verification failed");
    end
    $finish;
  end

endmodule
